// ----- rtl/core/refcounted_block_allocator_macros.svh -----
// Assertion macros used by the allocator executor (rba_back).
`ifndef REFCOUNTED_BLOCK_ALLOCATOR_MACROS_SVH
`define REFCOUNTED_BLOCK_ALLOCATOR_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define RBA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define RBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/rba_pkg.sv -----
package rba_pkg;

  localparam int unsigned MAX_BLOCKS = 4096;

  localparam int unsigned OP_W  = 3;
  localparam int unsigned FI_W  = 12;
  localparam int unsigned CNT_W = 16;
  localparam int unsigned BC_W  = 13;
  localparam int unsigned ST_W  = 2;
  localparam int unsigned FB_W  = 13;

  localparam logic [BC_W-1:0] BLOCK_COUNT_RESET = 13'd4096;
  localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;

  localparam logic [OP_W-1:0] OP_ALLOC_FIRST = 3'd0;
  localparam logic [OP_W-1:0] OP_ALLOC_AT    = 3'd1;
  localparam logic [OP_W-1:0] OP_FREE        = 3'd2;
  localparam logic [OP_W-1:0] OP_SET_RANGE   = 3'd3;
  localparam logic [OP_W-1:0] OP_COUNT_FREE  = 3'd4;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_NONE  = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

  typedef enum logic [2:0] {
    CMD_DONE,
    CMD_FIRST,
    CMD_AT,
    CMD_FREE,
    CMD_RANGE,
    CMD_COUNT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [FI_W-1:0]   first;
    logic [FI_W-1:0]   last;
    logic [CNT_W-1:0]  cnt;
    logic              rsv;
    logic [ST_W-1:0]   status;
    logic [FI_W-1:0]   idx;
  } cmd_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

endpackage

// ----- rtl/core/rba_if.sv -----
interface rba_in_if import rba_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [FI_W-1:0]  first_index;
  logic [FI_W-1:0]  last_index;
  logic [CNT_W-1:0] use_count;
  logic             reserved_flag;
  modport source (output valid, op, first_index, last_index, use_count, reserved_flag,
                  input ready);
  modport sink (input valid, op, first_index, last_index, use_count, reserved_flag,
                output ready);
endinterface

interface rba_out_if import rba_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ST_W-1:0] status;
  logic [FI_W-1:0] block_index;
  logic [FB_W-1:0] free_blocks;
  modport source (output valid, status, block_index, free_blocks, input ready);
  modport sink (input valid, status, block_index, free_blocks, output ready);
endinterface

interface rba_cfg_if import rba_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [BC_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ----- rtl/core/rba_front.sv -----
module rba_front import rba_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  rba_in_if.sink     in_ch,
  rba_cfg_if.sink    cfg_ch,
  output cmd_t       cmd,
  output logic       cmd_valid,
  input  logic       cmd_ready,
  input  back_stat_t bstat
);

  logic [BC_W-1:0] blk_cnt_r;
  logic [BC_W-1:0] n;
  logic [BC_W-1:0] n_m1;
  logic [FI_W-1:0] last_c;
  logic            in_rng;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_cnt_r <= BLOCK_COUNT_RESET;
    end else if (cfg_ch.valid) begin
      blk_cnt_r <= cfg_ch.data;
    end
  end

  assign in_ch.ready = cmd_ready && !bstat.clearing;
  assign cmd_valid   = in_ch.valid && !bstat.clearing;

  always_comb begin
    if (32'(blk_cnt_r) > MAX_BLOCKS) begin
      n = BC_W'(MAX_BLOCKS);
    end else begin
      n = blk_cnt_r;
    end
    n_m1   = n - 1'b1;
    in_rng = {1'b0, in_ch.first_index} < n;
    if ({1'b0, in_ch.last_index} > n_m1) begin
      last_c = n_m1[FI_W-1:0];
    end else begin
      last_c = in_ch.last_index;
    end

    cmd.kind   = CMD_DONE;
    cmd.first  = in_ch.first_index;
    cmd.last   = last_c;
    cmd.cnt    = in_ch.use_count;
    cmd.rsv    = in_ch.reserved_flag;
    cmd.status = ST_OK;
    cmd.idx    = in_ch.first_index;

    case (in_ch.op)
      OP_ALLOC_FIRST, OP_ALLOC_AT, OP_FREE, OP_SET_RANGE: begin
        if (!in_rng) begin
          cmd.status = ST_RANGE;
        end else if (in_ch.op == OP_ALLOC_FIRST) begin
          cmd.kind = CMD_FIRST;
          cmd.last = n_m1[FI_W-1:0];
        end else if (in_ch.op == OP_ALLOC_AT) begin
          cmd.kind = CMD_AT;
        end else if (in_ch.op == OP_FREE) begin
          cmd.kind = CMD_FREE;
        end else if (in_ch.first_index <= last_c) begin
          cmd.kind = CMD_RANGE;
        end
      end
      OP_COUNT_FREE: begin
        cmd.idx   = '0;
        cmd.first = '0;
        cmd.last  = n_m1[FI_W-1:0];
        if (n != '0) begin
          cmd.kind = CMD_COUNT;
        end
      end
      default: begin
        cmd.status = ST_RANGE;
        cmd.idx    = '0;
      end
    endcase
  end

endmodule

// ----- rtl/core/rba_queue.sv -----
module rba_queue import rba_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cmd_t wr_cmd,
  input  logic wr_valid,
  output logic wr_ready,
  output cmd_t rd_cmd,
  output logic rd_valid,
  input  logic rd_ready
);

  cmd_t       slot_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] fill_r;
  logic       wr_go;
  logic       rd_go;

  assign wr_ready = fill_r != 2'd2;
  assign rd_valid = fill_r != 2'd0;
  assign rd_cmd   = slot_r[rp_r];
  assign wr_go    = wr_valid && wr_ready;
  assign rd_go    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr_go) begin
      slot_r[wp_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      if (wr_go) begin
        wp_r <= !wp_r;
      end
      if (rd_go) begin
        rp_r <= !rp_r;
      end
      if (wr_go && !rd_go) begin
        fill_r <= fill_r + 2'd1;
      end else if (rd_go && !wr_go) begin
        fill_r <= fill_r - 2'd1;
      end
    end
  end

endmodule

// ----- rtl/core/rba_back.sv -----
module rba_back import rba_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       cmd,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  output back_stat_t bstat,
  rba_out_if.source  out_ch
);

  `include "refcounted_block_allocator_macros.svh"

  localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
  localparam int unsigned ENT_W = CNT_W + 1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_RMW_RD,
    S_RMW_WR,
    S_RANGE
  } state_t;

  logic [ENT_W-1:0] mem [MAX_BLOCKS];
  logic [ENT_W-1:0] rd_data_r;
  logic [IDX_W-1:0] rd_addr;
  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [ENT_W-1:0] wdata;

  state_t           st_r;
  cmd_t             cur_cmd_r;
  logic [IDX_W-1:0] cur_r;
  logic [IDX_W-1:0] last_r;
  logic             issue_r;
  logic             pend_r;
  logic [IDX_W-1:0] pend_idx_r;
  logic [FB_W-1:0]  zero_cnt_r;
  logic             out_valid_r;
  logic [ST_W-1:0]  out_status_r;
  logic [FI_W-1:0]  out_idx_r;
  logic [FB_W-1:0]  out_free_r;
  logic             cmd_take;
  logic [CNT_W-1:0] cnt_upd;

  assign bstat.clearing = st_r == S_CLEAR;
  assign cmd_ready      = st_r == S_IDLE && !out_valid_r;
  assign cmd_take       = cmd_ready && cmd_valid;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.block_index = out_idx_r;
  assign out_ch.free_blocks = out_free_r;

  always_comb begin
    rd_addr = cur_r;
    if (st_r == S_RMW_RD) begin
      rd_addr = IDX_W'(cur_cmd_r.first);
    end
    if (cur_cmd_r.kind == CMD_AT) begin
      cnt_upd = (rd_data_r[CNT_W-1:0] == COUNT_MAX) ? COUNT_MAX
                                                    : rd_data_r[CNT_W-1:0] + 1'b1;
    end else begin
      cnt_upd = (rd_data_r[CNT_W-1:0] == '0) ? '0 : rd_data_r[CNT_W-1:0] - 1'b1;
    end
    we    = 1'b0;
    waddr = cur_r;
    wdata = {cur_cmd_r.rsv, cur_cmd_r.cnt};
    case (st_r)
      S_CLEAR: begin
        we    = 1'b1;
        wdata = '0;
      end
      S_SCAN: begin
        waddr = pend_idx_r;
        wdata = {1'b0, CNT_W'(1)};
        we    = pend_r && cur_cmd_r.kind == CMD_FIRST && rd_data_r == '0;
      end
      S_RMW_WR: begin
        we    = 1'b1;
        waddr = IDX_W'(cur_cmd_r.first);
        wdata = {rd_data_r[CNT_W], cnt_upd};
      end
      S_RANGE: begin
        we = 1'b1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLEAR;
      cur_r       <= '0;
      issue_r     <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        S_CLEAR: begin
          cur_r <= cur_r + 1'b1;
          if (cur_r == IDX_W'(MAX_BLOCKS - 1)) begin
            st_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_take) begin
            cur_cmd_r  <= cmd;
            cur_r      <= IDX_W'(cmd.first);
            last_r     <= IDX_W'(cmd.last);
            zero_cnt_r <= '0;
            issue_r    <= 1'b1;
            pend_r     <= 1'b0;
            case (cmd.kind)
              CMD_FIRST, CMD_COUNT: st_r <= S_SCAN;
              CMD_AT, CMD_FREE:     st_r <= S_RMW_RD;
              CMD_RANGE:            st_r <= S_RANGE;
              default: begin
                out_valid_r  <= 1'b1;
                out_status_r <= cmd.status;
                out_idx_r    <= cmd.idx;
                out_free_r   <= '0;
              end
            endcase
          end
        end
        S_SCAN: begin
          pend_r     <= issue_r;
          pend_idx_r <= cur_r;
          if (issue_r) begin
            if (cur_r == last_r) begin
              issue_r <= 1'b0;
            end else begin
              cur_r <= cur_r + 1'b1;
            end
          end
          if (pend_r) begin
            if (cur_cmd_r.kind == CMD_FIRST) begin
              if (rd_data_r == '0) begin
                st_r         <= S_IDLE;
                issue_r      <= 1'b0;
                pend_r       <= 1'b0;
                out_valid_r  <= 1'b1;
                out_status_r <= ST_OK;
                out_idx_r    <= FI_W'(pend_idx_r);
                out_free_r   <= '0;
              end else if (pend_idx_r == last_r) begin
                st_r         <= S_IDLE;
                pend_r       <= 1'b0;
                out_valid_r  <= 1'b1;
                out_status_r <= ST_NONE;
                out_idx_r    <= '0;
                out_free_r   <= '0;
              end
            end else begin
              if (rd_data_r[CNT_W-1:0] == '0) begin
                zero_cnt_r <= zero_cnt_r + 1'b1;
              end
              if (pend_idx_r == last_r) begin
                st_r         <= S_IDLE;
                pend_r       <= 1'b0;
                out_valid_r  <= 1'b1;
                out_status_r <= ST_OK;
                out_idx_r    <= '0;
                out_free_r   <= zero_cnt_r + FB_W'(rd_data_r[CNT_W-1:0] == '0);
              end
            end
          end
        end
        S_RMW_RD: begin
          st_r <= S_RMW_WR;
        end
        S_RMW_WR: begin
          st_r         <= S_IDLE;
          out_valid_r  <= 1'b1;
          out_status_r <= ST_OK;
          out_idx_r    <= cur_cmd_r.first;
          out_free_r   <= '0;
        end
        S_RANGE: begin
          cur_r <= cur_r + 1'b1;
          if (cur_r == last_r) begin
            st_r         <= S_IDLE;
            out_valid_r  <= 1'b1;
            out_status_r <= ST_OK;
            out_idx_r    <= cur_cmd_r.first;
            out_free_r   <= '0;
          end
        end
        default: begin
          st_r <= S_IDLE;
        end
      endcase
    end
  end

  `RBA_ASSERT_SAME(a_take_free, clk, rst_n, cmd_take, st_r == S_IDLE, "Command taken while busy.")
  `RBA_ASSERT_SAME(a_pend_bound, clk, rst_n, pend_r, pend_idx_r <= last_r, "Scan overran.")
  `RBA_ASSERT_NEXT(a_clear_quiet, clk, rst_n, st_r == S_CLEAR, !out_valid_r, "Early result.")

endmodule

// ----- rtl/core/refcounted_block_allocator.sv -----
// Reference-counted block allocator with first-fit search.
// Commands enter on in_ch (op, first_index, last_index, use_count, reserved_flag)
// and each gives exactly one result item on out_ch (status, block_index,
// free_blocks). cfg_ch writes the block count and is always ready.
// A classifier checks indices and forwards work through a two-entry queue to an
// executor owning the count store, one entry per cycle on a read and a write port.
// Allocate at index and free read an entry, then write it back; range set writes
// each block of the range in turn; first-fit reads entries from first_index until
// it finds a free one or reaches the last block; a count query reads every block.
// Items are carried out one at a time: the next one starts executing in the
// cycle after the previous result item has been accepted.
// After reset a clearing pass zeroes every store entry, during which no item is
// accepted; configuration writes are still taken.
// A result waits in the output register while out_ch.ready is low; meanwhile up
// to two further items are accepted into the queue before in_ch.ready drops.
module refcounted_block_allocator import rba_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  rba_in_if.sink    in_ch,
  rba_cfg_if.sink   cfg_ch,
  rba_out_if.source out_ch
);

  cmd_t       f_cmd;
  logic       f_valid;
  logic       f_ready;
  cmd_t       q_cmd;
  logic       q_valid;
  logic       q_ready;
  back_stat_t bstat;

  rba_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .cmd       (f_cmd),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .bstat     (bstat)
  );

  rba_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_cmd   (f_cmd),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .rd_cmd   (q_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready)
  );

  rba_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (q_cmd),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .bstat     (bstat),
    .out_ch    (out_ch)
  );

endmodule
